### src/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types, codes and sizes of the pattern step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

   // table sizes
   localparam int PATTERN_DEPTH = 64;
   localparam int GROUP_DEPTH   = 64;
   localparam int CHORD_MAX     = 8;
   localparam int VEL_DEPTH     = 64;
   localparam int QUARTER_TICKS = 96;

   localparam int PAT_AW   = $clog2(PATTERN_DEPTH);
   localparam int GRP_AW   = $clog2(GROUP_DEPTH);
   localparam int SLOT_W   = $clog2(CHORD_MAX);
   localparam int VEL_AW   = $clog2(VEL_DEPTH);
   localparam int PITCH_AW = GRP_AW + SLOT_W;

   // field widths
   localparam int CMD_W   = 3;
   localparam int IDX_W   = 6;
   localparam int VALUE_W = 15;
   localparam int NOTE_W  = 7;
   localparam int SIZE_W  = 4;
   localparam int TICK_W  = 14;
   localparam int LEN_W   = 7;
   localparam int CSR_AW  = 2;

   // floor(y / 10) as (y * RECIP_10) >> RECIP_SHIFT, low by at most one
   localparam int RECIP_10    = 13107;
   localparam int RECIP_SHIFT = 17;
   localparam int GATE_MAX    = 14745;

   // transaction queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WR_PAT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WR_CHORD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WR_VEL    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART   = 3'd4;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_PATTERN_LEN = 2'd0;
   localparam logic [CSR_AW-1:0] REG_GROUP_COUNT = 2'd1;
   localparam logic [CSR_AW-1:0] REG_VEL_COUNT   = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_TICK,
      OP_WR_PAT,
      OP_WR_CHORD,
      OP_WR_VEL,
      OP_RESTART
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_GATE,
      ST_EMIT
   } state_type;

   // one classified transaction
   typedef struct packed {
      op_type                    op;
      logic [IDX_W-1:0]          index;
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] value;
      logic [NOTE_W-1:0]         sat;
      logic                      slot_last;
   } entry_type;

   typedef struct packed {
      logic [LEN_W-1:0] pattern_len;
      logic [LEN_W-1:0] group_count;
      logic [LEN_W-1:0] vel_count;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // clamp a signed write value to 0..127
   function automatic logic [NOTE_W-1:0] sat_note(input logic signed [VALUE_W-1:0] v);
      logic [NOTE_W-1:0] r;
      if (v[VALUE_W-1]) begin
         r = '0;
      end else if (v[VALUE_W-2:NOTE_W] != '0) begin
         r = '1;
      end else begin
         r = v[NOTE_W-1:0];
      end
      return r;
   endfunction

   // effective table length, limited to the depth
   function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W-1:0] v,
                                                input logic [LEN_W-1:0] depth);
      return (v < depth) ? v : depth;
   endfunction

endpackage

`default_nettype wire

### src/pattern_step_sequencer.sv
// The back runs one queued entry at a time. A table write, restart or tick
// over an empty table ends as its entry is popped in IDLE; a tick with no
// notes ends after CALC; a note-on tick forms the gate in CALC and GATE, then
// sends its chord from EMIT, one pitch read a cycle unless the output stalls.
// A 4-entry queue lets requests be taken while a chord is still going out.
// Reset (synchronous) clears indices, phase, registers and queue; tables are not.
// ----------------------------------------------------------------------------
// pattern_step_sequencer
// Tick-driven step sequencer emitting chord notes from duration, chord and
// velocity tables.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_step_sequencer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [psq_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [psq_pkg::IDX_W-1:0]          req_index,
   input  wire logic [psq_pkg::SLOT_W-1:0]         req_slot,
   input  wire logic signed [psq_pkg::VALUE_W-1:0] req_value,
   input  wire logic                               req_slot_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [psq_pkg::NOTE_W-1:0]              rsp_pitch,
   output logic [psq_pkg::NOTE_W-1:0]              rsp_velocity,
   output logic [psq_pkg::TICK_W-1:0]              rsp_gate_ticks,
   output logic                                    rsp_last,
   input  wire logic                               csr_we,
   input  wire logic [psq_pkg::CSR_AW-1:0]         csr_index,
   input  wire logic [psq_pkg::LEN_W-1:0]          csr_wdata
);

   psq_pkg::cfg_type   cfg_ff, cfg_in;
   psq_pkg::entry_type push_entry, head_entry;
   psq_pkg::qstat_type q_stat;
   logic               q_push, q_pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            psq_pkg::REG_PATTERN_LEN: cfg_in.pattern_len = csr_wdata;
            psq_pkg::REG_GROUP_COUNT: cfg_in.group_count = csr_wdata;
            psq_pkg::REG_VEL_COUNT:   cfg_in.vel_count   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and decode
   psq_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_index     (req_index),
      .req_slot      (req_slot),
      .req_value     (req_value),
      .req_slot_last (req_slot_last),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // transaction queue
   psq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   // back: execute and emit
   psq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_entry     (head_entry),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pitch      (rsp_pitch),
      .rsp_velocity   (rsp_velocity),
      .rsp_gate_ticks (rsp_gate_ticks),
      .rsp_last       (rsp_last)
   );

   // back never pops an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   // gate stays within ninety percent of the longest step
   a_gate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gate_ticks <= psq_pkg::TICK_W'(psq_pkg::GATE_MAX)))
      else $error("gate length out of range");

   // no result pending straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

### src/psq_front.sv
// ----------------------------------------------------------------------------
// psq_front
// Accepts request transactions, decodes the command and saturates note values.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_front (
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [psq_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [psq_pkg::IDX_W-1:0]          req_index,
   input  wire logic [psq_pkg::SLOT_W-1:0]         req_slot,
   input  wire logic signed [psq_pkg::VALUE_W-1:0] req_value,
   input  wire logic                               req_slot_last,
   input  wire psq_pkg::qstat_type                 q_stat,
   output logic                                    q_push,
   output psq_pkg::entry_type                      q_entry
);

   // accept whenever the queue has room
   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   // command decode
   always_comb begin
      q_entry.index     = req_index;
      q_entry.slot      = req_slot;
      q_entry.value     = req_value;
      q_entry.sat       = psq_pkg::sat_note(req_value);
      q_entry.slot_last = req_slot_last;
      unique case (req_cmd)
         psq_pkg::CMD_TICK:     q_entry.op = psq_pkg::OP_TICK;
         psq_pkg::CMD_WR_PAT:   q_entry.op = psq_pkg::OP_WR_PAT;
         psq_pkg::CMD_WR_CHORD: q_entry.op = psq_pkg::OP_WR_CHORD;
         psq_pkg::CMD_WR_VEL:   q_entry.op = psq_pkg::OP_WR_VEL;
         psq_pkg::CMD_RESTART:  q_entry.op = psq_pkg::OP_RESTART;
         default:               q_entry.op = psq_pkg::OP_NOP;
      endcase
   end

endmodule

`default_nettype wire

### src/psq_queue.sv
// ----------------------------------------------------------------------------
// psq_queue
// Short first-in first-out queue of decoded transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire psq_pkg::entry_type push_entry,
   input  wire logic               pop,
   output psq_pkg::entry_type      head_entry,
   output psq_pkg::qstat_type      q_stat
);

   psq_pkg::entry_type                 slots_ff [psq_pkg::QUEUE_DEPTH];
   logic [psq_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [psq_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [psq_pkg::QUEUE_AW:0]         count_ff, count_in;
   logic                               do_push, do_pop;

   assign q_stat.full  = (count_ff == (psq_pkg::QUEUE_AW+1)'(psq_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_entry   = slots_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (psq_pkg::QUEUE_AW+1)'(do_push)
                           - (psq_pkg::QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### src/psq_back.sv
// ----------------------------------------------------------------------------
// psq_back
// Executes queued transactions: table writes, restart and tick sequencing,
// with chord notes out of the result register one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire psq_pkg::cfg_type            cfg,
   input  wire psq_pkg::entry_type          head_entry,
   input  wire psq_pkg::qstat_type          q_stat,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [psq_pkg::NOTE_W-1:0]       rsp_pitch,
   output logic [psq_pkg::NOTE_W-1:0]       rsp_velocity,
   output logic [psq_pkg::TICK_W-1:0]       rsp_gate_ticks,
   output logic                             rsp_last
);

   localparam int LW = psq_pkg::LEN_W;
   localparam int TW = psq_pkg::TICK_W;
   localparam int YW = TW + 4;
   localparam int PW = 2 * TW + 4;

   // memories
   logic signed [psq_pkg::VALUE_W-1:0] pat_mem   [psq_pkg::PATTERN_DEPTH];
   logic [psq_pkg::NOTE_W-1:0]         pitch_mem [psq_pkg::GROUP_DEPTH * psq_pkg::CHORD_MAX];
   logic [psq_pkg::SIZE_W-1:0]         size_mem  [psq_pkg::GROUP_DEPTH];
   logic [psq_pkg::NOTE_W-1:0]         vel_mem   [psq_pkg::VEL_DEPTH];

   logic signed [psq_pkg::VALUE_W-1:0] pat_rd_ff;
   logic [psq_pkg::NOTE_W-1:0]         pitch_rd_ff;
   logic [psq_pkg::SIZE_W-1:0]         size_rd_ff;
   logic [psq_pkg::NOTE_W-1:0]         vel_rd_ff;

   // control state
   psq_pkg::state_type                 state_ff, state_in;
   logic [psq_pkg::PAT_AW-1:0]         step_ff, step_in;
   logic [psq_pkg::GRP_AW-1:0]         group_ff, group_in;
   logic [psq_pkg::VEL_AW-1:0]         vel_ff, vel_in;
   logic [TW-1:0]                      ticks_ff, ticks_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // per-tick working registers
   logic [psq_pkg::GRP_AW-1:0]         cur_group_ff, cur_group_in;
   logic [psq_pkg::SIZE_W-1:0]         size_ff, size_in;
   logic [psq_pkg::SLOT_W-1:0]         k_ff, k_in;
   logic [YW-1:0]                      y_ff, y_in;
   logic [PW-1:0]                      prod_ff, prod_in;
   logic [TW-1:0]                      gate_ff, gate_in;
   logic [psq_pkg::NOTE_W-1:0]         rsp_pitch_ff, rsp_pitch_in;
   logic [psq_pkg::NOTE_W-1:0]         rsp_vel_ff, rsp_vel_in;
   logic [TW-1:0]                      rsp_gate_ff, rsp_gate_in;
   logic                               rsp_last_ff, rsp_last_in;

   // memory ports
   logic                               pat_we, pitch_we, size_we, vel_we, rd_en;
   logic [psq_pkg::PAT_AW-1:0]         pat_raddr;
   logic [psq_pkg::GRP_AW-1:0]         size_raddr;
   logic [psq_pkg::VEL_AW-1:0]         vel_raddr;
   logic [psq_pkg::PITCH_AW-1:0]       pitch_raddr, pitch_waddr;
   logic [psq_pkg::SLOT_W-1:0]         k_rd;

   // decode helpers
   logic [LW-1:0]                      plen, glen, vlen;
   logic                               lens_ok;
   logic [psq_pkg::PAT_AW-1:0]         step_eff;
   logic [psq_pkg::GRP_AW-1:0]         group_eff;
   logic [psq_pkg::VEL_AW-1:0]         vel_eff;
   logic                               head_valid, is_tick, emit_load, emit_done;
   logic                               dur_neg, dur_zero, note_on;
   logic [TW:0]                        dur_mag, total;
   logic [TW-1:0]                      dur_pos;
   logic [psq_pkg::SIZE_W-1:0]         size_eff;
   logic [TW:0]                        q0;
   logic [YW-1:0]                      rem;

   assign plen = psq_pkg::cap_len(cfg.pattern_len, LW'(psq_pkg::PATTERN_DEPTH));
   assign glen = psq_pkg::cap_len(cfg.group_count, LW'(psq_pkg::GROUP_DEPTH));
   assign vlen = psq_pkg::cap_len(cfg.vel_count, LW'(psq_pkg::VEL_DEPTH));
   assign lens_ok = (plen != '0) && (glen != '0) && (vlen != '0);

   // an index at or beyond its length restarts at zero
   assign step_eff  = (LW'(step_ff)  >= plen) ? '0 : step_ff;
   assign group_eff = (LW'(group_ff) >= glen) ? '0 : group_ff;
   assign vel_eff   = (LW'(vel_ff)   >= vlen) ? '0 : vel_ff;

   assign head_valid = !q_stat.empty;
   assign is_tick    = head_valid && (head_entry.op == psq_pkg::OP_TICK) && lens_ok;
   assign emit_load  = !rsp_valid_ff || rsp_ready;
   assign emit_done  = ({1'b0, k_ff} + psq_pkg::SIZE_W'(1)) == size_ff;

   // step duration from the pattern entry
   assign dur_neg  = pat_rd_ff[psq_pkg::VALUE_W-1];
   assign dur_zero = (pat_rd_ff == '0);
   assign dur_mag  = dur_neg ? (TW+1)'(-pat_rd_ff) : (TW+1)'(pat_rd_ff);
   assign total    = dur_zero ? (TW+1)'(psq_pkg::QUARTER_TICKS) : dur_mag;
   assign dur_pos  = dur_zero ? TW'(psq_pkg::QUARTER_TICKS) : pat_rd_ff[TW-1:0];
   assign note_on  = (ticks_ff == '0) && !dur_neg;
   assign size_eff = (size_rd_ff > psq_pkg::SIZE_W'(psq_pkg::CHORD_MAX))
                     ? psq_pkg::SIZE_W'(psq_pkg::CHORD_MAX) : size_rd_ff;

   // gate = floor(9 * d / 10): reciprocal estimate plus one correction
   assign q0  = prod_ff[psq_pkg::RECIP_SHIFT +: TW+1];
   assign rem = y_ff - (YW'(q0) << 3) - (YW'(q0) << 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psq_pkg::ST_IDLE: begin
            if (is_tick) state_in = psq_pkg::ST_CALC;
         end
         psq_pkg::ST_CALC: begin
            if (note_on && (size_eff != '0)) state_in = psq_pkg::ST_GATE;
            else                            state_in = psq_pkg::ST_IDLE;
         end
         psq_pkg::ST_GATE: begin
            state_in = psq_pkg::ST_EMIT;
         end
         psq_pkg::ST_EMIT: begin
            if (emit_load && emit_done) state_in = psq_pkg::ST_IDLE;
         end
         default: state_in = psq_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      pat_we       = 1'b0;
      pitch_we     = 1'b0;
      size_we      = 1'b0;
      vel_we       = 1'b0;
      rd_en        = 1'b0;
      step_in      = step_ff;
      group_in     = group_ff;
      vel_in       = vel_ff;
      ticks_in     = ticks_ff;
      cur_group_in = cur_group_ff;
      size_in      = size_ff;
      k_in         = k_ff;
      k_rd         = k_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      gate_in      = gate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_gate_in  = rsp_gate_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         psq_pkg::ST_IDLE: begin
            if (head_valid) begin
               q_pop = 1'b1;
               unique case (head_entry.op)
                  psq_pkg::OP_WR_PAT:   pat_we = 1'b1;
                  psq_pkg::OP_WR_CHORD: begin
                     pitch_we = 1'b1;
                     size_we  = head_entry.slot_last;
                  end
                  psq_pkg::OP_WR_VEL:   vel_we = 1'b1;
                  psq_pkg::OP_RESTART: begin
                     step_in  = '0;
                     group_in = '0;
                     vel_in   = '0;
                     ticks_in = '0;
                  end
                  psq_pkg::OP_TICK: begin
                     if (lens_ok) begin
                        rd_en    = 1'b1;
                        step_in  = step_eff;
                        group_in = group_eff;
                        vel_in   = vel_eff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         psq_pkg::ST_CALC: begin
            // phase advance
            if ((TW+1)'(ticks_ff) + (TW+1)'(1) >= total) begin
               ticks_in = '0;
               step_in  = (LW'(step_ff) + LW'(1) == plen) ? '0 : step_ff + 1'b1;
            end else begin
               ticks_in = ticks_ff + 1'b1;
            end
            // note-on: latch chord and move group and velocity on
            if (note_on) begin
               cur_group_in = group_ff;
               size_in      = size_eff;
               k_in         = '0;
               k_rd         = '0;
               y_in         = (YW'(dur_pos) << 3) + YW'(dur_pos);
               prod_in      = PW'(y_in) * PW'(psq_pkg::RECIP_10);
               group_in     = (LW'(group_ff) + LW'(1) == glen) ? '0 : group_ff + 1'b1;
               vel_in       = (LW'(vel_ff) + LW'(1) == vlen) ? '0 : vel_ff + 1'b1;
            end
         end
         psq_pkg::ST_GATE: begin
            gate_in = (rem >= YW'(10)) ? TW'(q0 + (TW+1)'(1)) : TW'(q0);
         end
         psq_pkg::ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_pitch_in = pitch_rd_ff;
               rsp_vel_in   = vel_rd_ff;
               rsp_gate_in  = gate_ff;
               rsp_last_in  = emit_done;
               k_in         = k_ff + 1'b1;
               k_rd         = k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign pat_raddr   = step_eff;
   assign size_raddr  = group_eff;
   assign vel_raddr   = vel_eff;
   assign pitch_raddr = {cur_group_in, k_rd};
   assign pitch_waddr = {head_entry.index[psq_pkg::GRP_AW-1:0], head_entry.slot};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psq_pkg::ST_IDLE;
         step_ff      <= '0;
         group_ff     <= '0;
         vel_ff       <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         group_ff     <= group_in;
         vel_ff       <= vel_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      cur_group_ff <= cur_group_in;
      size_ff      <= size_in;
      k_ff         <= k_in;
      y_ff         <= y_in;
      prod_ff      <= prod_in;
      gate_ff      <= gate_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_gate_ff  <= rsp_gate_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // pattern, size and velocity tables
   always_ff @(posedge clock) begin
      if (pat_we) pat_mem[head_entry.index[psq_pkg::PAT_AW-1:0]] <= head_entry.value;
      if (size_we) begin
         size_mem[head_entry.index[psq_pkg::GRP_AW-1:0]] <=
            psq_pkg::SIZE_W'(head_entry.slot) + psq_pkg::SIZE_W'(1);
      end
      if (vel_we) vel_mem[head_entry.index[psq_pkg::VEL_AW-1:0]] <= head_entry.sat;
      if (rd_en) begin
         pat_rd_ff  <= pat_mem[pat_raddr];
         size_rd_ff <= size_mem[size_raddr];
         vel_rd_ff  <= vel_mem[vel_raddr];
      end
   end

   // chord pitch table
   always_ff @(posedge clock) begin
      if (pitch_we) pitch_mem[pitch_waddr] <= head_entry.sat;
      pitch_rd_ff <= pitch_mem[pitch_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pitch      = rsp_pitch_ff;
   assign rsp_velocity   = rsp_vel_ff;
   assign rsp_gate_ticks = rsp_gate_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

### sim/tb_pattern_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pattern_step_sequencer
// Self-checking bench for the step sequencer: loads the duration, chord and
// velocity tables through write requests, plays ticks under random idling and
// backpressure, and checks every emitted note against an in-bench predictor.
// ----------------------------------------------------------------------------

module tb_pattern_step_sequencer;

   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASE_ITEMS    = 62;
   localparam int NUM_PHASES     = 6;

   // codes the block has to ignore
   localparam logic [psq_pkg::CMD_W-1:0]  CMD_FIRST_UNUSED = 3'd5;
   localparam logic [psq_pkg::CMD_W-1:0]  CMD_LAST_CODE    = 3'd7;
   localparam logic [psq_pkg::CSR_AW-1:0] REG_SPARE        = 2'd3;

   typedef struct packed {
      logic [psq_pkg::NOTE_W-1:0] pitch;
      logic [psq_pkg::NOTE_W-1:0] velocity;
      logic [psq_pkg::TICK_W-1:0] gate_ticks;
      logic                       last;
   } note_type;

   // predicted sequencer state and the notes still owed by the block
   class chord_note_tracker;
      logic signed [psq_pkg::VALUE_W-1:0] step_len_tbl [psq_pkg::PATTERN_DEPTH];
      logic [psq_pkg::NOTE_W-1:0]  chord_note [psq_pkg::GROUP_DEPTH][psq_pkg::CHORD_MAX];
      logic [psq_pkg::SIZE_W-1:0]  chord_size [psq_pkg::GROUP_DEPTH];
      logic [psq_pkg::NOTE_W-1:0]  vel_tbl [psq_pkg::VEL_DEPTH];
      logic [psq_pkg::LEN_W-1:0]   pattern_len;
      logic [psq_pkg::LEN_W-1:0]   group_count;
      logic [psq_pkg::LEN_W-1:0]   vel_count;
      int unsigned                 step_pos;
      int unsigned                 group_pos;
      int unsigned                 vel_pos;
      int unsigned                 tick_count;
      note_type                    due_notes[$];
      int                          error_count;

      function new();
         pattern_len = '0;
         group_count = '0;
         vel_count   = '0;
         step_pos    = 0;
         group_pos   = 0;
         vel_pos     = 0;
         tick_count  = 0;
         error_count = 0;
      endfunction

      function int unsigned eff_len(input logic [psq_pkg::LEN_W-1:0] r,
                                    input int unsigned depth);
         return (r < depth) ? r : depth;
      endfunction

      function logic [psq_pkg::NOTE_W-1:0] clamp_note(
            input logic signed [psq_pkg::VALUE_W-1:0] v);
         if (v < 0) return '0;
         if (v > 127) return '1;
         return v[psq_pkg::NOTE_W-1:0];
      endfunction

      function void write_reg(input logic [psq_pkg::CSR_AW-1:0] idx,
                              input logic [psq_pkg::LEN_W-1:0] data);
         case (idx)
            psq_pkg::REG_PATTERN_LEN: pattern_len = data;
            psq_pkg::REG_GROUP_COUNT: group_count = data;
            psq_pkg::REG_VEL_COUNT:   vel_count   = data;
            default: ;
         endcase
      endfunction

      // one tick of musical time: maybe start a chord, then move the phase on
      function void play_tick();
         int unsigned plen, glen, vlen, total, notes, gate, k;
         int          dur;
         note_type    n;
         plen = eff_len(pattern_len, psq_pkg::PATTERN_DEPTH);
         glen = eff_len(group_count, psq_pkg::GROUP_DEPTH);
         vlen = eff_len(vel_count, psq_pkg::VEL_DEPTH);
         if (plen == 0 || glen == 0 || vlen == 0) return;
         if (step_pos >= plen) step_pos = 0;
         if (group_pos >= glen) group_pos = 0;
         if (vel_pos >= vlen) vel_pos = 0;
         dur = int'(step_len_tbl[step_pos]);
         // zero length plays as a quarter note
         if (dur == 0) dur = psq_pkg::QUARTER_TICKS;
         total = (dur < 0) ? -dur : dur;
         if (tick_count == 0 && dur > 0) begin
            notes = chord_size[group_pos];
            if (notes > psq_pkg::CHORD_MAX) notes = psq_pkg::CHORD_MAX;
            gate = (dur * 9) / 10;
            for (k = 0; k < notes; k++) begin
               n.pitch      = chord_note[group_pos][k];
               n.velocity   = vel_tbl[vel_pos];
               n.gate_ticks = gate[psq_pkg::TICK_W-1:0];
               n.last       = (k + 1 == notes);
               due_notes.insert(due_notes.size(), n);
            end
            group_pos = (group_pos + 1) % glen;
            vel_pos   = (vel_pos + 1) % vlen;
         end
         // step ends once its length is reached, or at once after an overrun
         if (tick_count + 1 >= total) begin
            tick_count = 0;
            step_pos   = (step_pos + 1) % plen;
         end else begin
            tick_count++;
         end
      endfunction

      function void take_request(input logic [psq_pkg::CMD_W-1:0] cmd,
                                 input logic [psq_pkg::IDX_W-1:0] idx,
                                 input logic [psq_pkg::SLOT_W-1:0] slot,
                                 input logic signed [psq_pkg::VALUE_W-1:0] value,
                                 input logic slast);
         case (cmd)
            psq_pkg::CMD_TICK:     play_tick();
            psq_pkg::CMD_WR_PAT:   step_len_tbl[idx] = value;
            psq_pkg::CMD_WR_CHORD: begin
               chord_note[idx][slot] = clamp_note(value);
               if (slast) chord_size[idx] = {1'b0, slot} + 4'd1;
            end
            psq_pkg::CMD_WR_VEL:   vel_tbl[idx] = clamp_note(value);
            psq_pkg::CMD_RESTART:  begin
               step_pos   = 0;
               group_pos  = 0;
               vel_pos    = 0;
               tick_count = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_note(input note_type got);
         note_type want;
         if (due_notes.size() == 0) begin
            $error("unexpected note: pitch %0d velocity %0d gate_ticks %0d last %0d",
                   got.pitch, got.velocity, got.gate_ticks, got.last);
            error_count++;
            return;
         end
         want = due_notes.pop_front();
         if (got.pitch !== want.pitch) begin
            $error("pitch: expected %0d, actual %0d", want.pitch, got.pitch);
            error_count++;
         end
         if (got.velocity !== want.velocity) begin
            $error("velocity: expected %0d, actual %0d", want.velocity, got.velocity);
            error_count++;
         end
         if (got.gate_ticks !== want.gate_ticks) begin
            $error("gate_ticks: expected %0d, actual %0d", want.gate_ticks, got.gate_ticks);
            error_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [psq_pkg::CMD_W-1:0]          req_cmd;
   logic [psq_pkg::IDX_W-1:0]          req_index;
   logic [psq_pkg::SLOT_W-1:0]         req_slot;
   logic signed [psq_pkg::VALUE_W-1:0] req_value;
   logic                               req_slot_last;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [psq_pkg::NOTE_W-1:0]         rsp_pitch;
   logic [psq_pkg::NOTE_W-1:0]         rsp_velocity;
   logic [psq_pkg::TICK_W-1:0]         rsp_gate_ticks;
   logic                               rsp_last;
   logic                               csr_we;
   logic [psq_pkg::CSR_AW-1:0]         csr_index;
   logic [psq_pkg::LEN_W-1:0]          csr_wdata;

   chord_note_tracker sb;
   int                tx_idle_pct;
   int                rx_idle_pct;
   bit                hold_off_req;
   int                cycle_count;
   int                items_sent;

   // which table entries hold a written value
   bit pat_set   [psq_pkg::PATTERN_DEPTH];
   bit size_set  [psq_pkg::GROUP_DEPTH];
   bit pitch_set [psq_pkg::GROUP_DEPTH][psq_pkg::CHORD_MAX];
   bit vel_set   [psq_pkg::VEL_DEPTH];

   pattern_step_sequencer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_index      (req_index),
      .req_slot       (req_slot),
      .req_value      (req_value),
      .req_slot_last  (req_slot_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pitch      (rsp_pitch),
      .rsp_velocity   (rsp_velocity),
      .rsp_gate_ticks (rsp_gate_ticks),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // random stimulus values
   function automatic logic signed [psq_pkg::VALUE_W-1:0] rand_duration();
      int unsigned pick;
      int          d;
      pick = $urandom_range(0, 99);
      if (pick < 55) d = $urandom_range(1, 4);
      else if (pick < 70) d = 0;
      else if (pick < 96) d = -int'($urandom_range(1, 3));
      else d = $urandom;
      return d[psq_pkg::VALUE_W-1:0];
   endfunction

   function automatic logic signed [psq_pkg::VALUE_W-1:0] rand_note_value();
      int d;
      if ($urandom_range(0, 99) < 80) d = $urandom_range(0, 127);
      else d = $urandom;
      return d[psq_pkg::VALUE_W-1:0];
   endfunction

   function automatic logic [psq_pkg::SLOT_W-1:0] rand_slot();
      return psq_pkg::SLOT_W'($urandom_range(0, psq_pkg::CHORD_MAX - 1));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [psq_pkg::IDX_W-1:0] rand_index();
      return psq_pkg::IDX_W'($urandom_range(0, 63));
   endfunction

   // mostly an entry in use, sometimes anywhere in the table
   function automatic logic [psq_pkg::IDX_W-1:0] pick_index(
         input logic [psq_pkg::LEN_W-1:0] reg_val, input int unsigned depth);
      int unsigned used;
      used = sb.eff_len(reg_val, depth);
      if (used > 0 && $urandom_range(0, 3) != 0)
         return psq_pkg::IDX_W'($urandom_range(0, used - 1));
      return psq_pkg::IDX_W'($urandom_range(0, depth - 1));
   endfunction

   // one request transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [psq_pkg::CMD_W-1:0] cmd,
                            input logic [psq_pkg::IDX_W-1:0] idx,
                            input logic [psq_pkg::SLOT_W-1:0] slot,
                            input logic signed [psq_pkg::VALUE_W-1:0] value,
                            input logic slast);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_index     <= idx;
      req_slot      <= slot;
      req_value     <= value;
      req_slot_last <= slast;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      sb.take_request(cmd, idx, slot, value, slast);
      case (cmd)
         psq_pkg::CMD_WR_PAT:   pat_set[idx] = 1'b1;
         psq_pkg::CMD_WR_CHORD: begin
            pitch_set[idx][slot] = 1'b1;
            if (slast) size_set[idx] = 1'b1;
         end
         psq_pkg::CMD_WR_VEL:   vel_set[idx] = 1'b1;
         default: ;
      endcase
   endtask

   // tick, after filling any table entry that this tick is going to read
   task automatic send_tick();
      int unsigned plen, glen, vlen, s, g, v, k;
      int          dur;
      plen = sb.eff_len(sb.pattern_len, psq_pkg::PATTERN_DEPTH);
      glen = sb.eff_len(sb.group_count, psq_pkg::GROUP_DEPTH);
      vlen = sb.eff_len(sb.vel_count, psq_pkg::VEL_DEPTH);
      if (plen != 0 && glen != 0 && vlen != 0) begin
         s = (sb.step_pos >= plen) ? 0 : sb.step_pos;
         g = (sb.group_pos >= glen) ? 0 : sb.group_pos;
         v = (sb.vel_pos >= vlen) ? 0 : sb.vel_pos;
         if (!pat_set[s])
            send_item(psq_pkg::CMD_WR_PAT, psq_pkg::IDX_W'(s), rand_slot(),
                      rand_duration(), rand_bit());
         dur = int'(sb.step_len_tbl[s]);
         if (sb.tick_count == 0 && dur >= 0) begin
            if (!size_set[g])
               send_item(psq_pkg::CMD_WR_CHORD, psq_pkg::IDX_W'(g), rand_slot(),
                         rand_note_value(), 1'b1);
            for (k = 0; k < sb.chord_size[g]; k++) begin
               if (!pitch_set[g][k])
                  send_item(psq_pkg::CMD_WR_CHORD, psq_pkg::IDX_W'(g),
                            psq_pkg::SLOT_W'(k), rand_note_value(), 1'b0);
            end
            if (!vel_set[v])
               send_item(psq_pkg::CMD_WR_VEL, psq_pkg::IDX_W'(v), rand_slot(),
                         rand_note_value(), rand_bit());
         end
      end
      send_item(psq_pkg::CMD_TICK, rand_index(), rand_slot(),
                psq_pkg::VALUE_W'($urandom), rand_bit());
   endtask

   // sender quiet until every owed note is out, then through a settling wait
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.due_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [psq_pkg::CSR_AW-1:0] idx,
                          input logic [psq_pkg::LEN_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic set_lengths(input logic [psq_pkg::LEN_W-1:0] p,
                              input logic [psq_pkg::LEN_W-1:0] g,
                              input logic [psq_pkg::LEN_W-1:0] v);
      logic [psq_pkg::LEN_W-1:0] spare;
      spare = psq_pkg::LEN_W'($urandom);
      put_reg(psq_pkg::REG_PATTERN_LEN, p);
      put_reg(psq_pkg::REG_GROUP_COUNT, g);
      put_reg(psq_pkg::REG_VEL_COUNT, v);
      put_reg(REG_SPARE, spare);
      csr_we <= 1'b0;
   endtask

   // random traffic, mostly ticks over well-formed tables; table fills count too
   task automatic run_random_phase(input int count, input bit pause_midway);
      int          start;
      int unsigned pick;
      bit          paused;
      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < count) begin
         if (pause_midway && !paused && items_sent - start >= count / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_item(psq_pkg::CMD_WR_PAT,
                      pick_index(sb.pattern_len, psq_pkg::PATTERN_DEPTH),
                      rand_slot(), rand_duration(), rand_bit());
         end else if (pick < 24) begin
            send_item(psq_pkg::CMD_WR_CHORD,
                      pick_index(sb.group_count, psq_pkg::GROUP_DEPTH),
                      rand_slot(), rand_note_value(), $urandom_range(0, 9) < 3);
         end else if (pick < 34) begin
            send_item(psq_pkg::CMD_WR_VEL, pick_index(sb.vel_count, psq_pkg::VEL_DEPTH),
                      rand_slot(), rand_note_value(), rand_bit());
         end else if (pick < 39) begin
            send_item(psq_pkg::CMD_RESTART, rand_index(), rand_slot(),
                      psq_pkg::VALUE_W'($urandom), rand_bit());
         end else if (pick < 42) begin
            // codes the block ignores
            send_item(psq_pkg::CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE)),
                      rand_index(), rand_slot(), psq_pkg::VALUE_W'($urandom),
                      rand_bit());
         end else begin
            send_tick();
         end
      end
   endtask

   // note checking on the response channel
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_note('{rsp_pitch, rsp_velocity, rsp_gate_ticks, rsp_last});
   end

   // response side ready, with an occasional long hold-off
   initial begin
      int hold_cnt;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_pattern_step_sequencer: done, errors");
      $finish;
   end

   initial begin
      int                        k, ph;
      int                        chord_vals [psq_pkg::CHORD_MAX];
      logic [psq_pkg::LEN_W-1:0] phase_len [NUM_PHASES][3];
      chord_vals    = '{-16384, -1, 128, 127, 0, 64, 200, 16383};
      phase_len     = '{'{7'd4, 7'd3, 7'd2}, '{7'd64, 7'd64, 7'd64},
                        '{7'd127, 7'd127, 7'd1}, '{7'd0, 7'd5, 7'd5},
                        '{7'd9, 7'd6, 7'd127}, '{7'd3, 7'd64, 7'd17}};
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= psq_pkg::CMD_TICK;
      req_index     <= '0;
      req_slot      <= '0;
      req_value     <= '0;
      req_slot_last <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= psq_pkg::REG_PATTERN_LEN;
      csr_wdata     <= '0;
      sb            = new();
      items_sent    = 0;
      tx_idle_pct   = 27;
      rx_idle_pct   = 62;
      hold_off_req  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty tables: ticks, ignored codes and restart do nothing
      send_tick();
      send_item(CMD_FIRST_UNUSED, '1, '1, psq_pkg::VALUE_W'(-16384), 1'b1);
      send_item(CMD_LAST_CODE, '0, '0, psq_pkg::VALUE_W'(16383), 1'b0);
      send_item(psq_pkg::CMD_RESTART, '1, '1, '1, 1'b1);

      // full chord in group 0 with saturating pitch values
      for (k = 0; k < psq_pkg::CHORD_MAX; k++)
         send_item(psq_pkg::CMD_WR_CHORD, '0, psq_pkg::SLOT_W'(k),
                   psq_pkg::VALUE_W'(chord_vals[k]), k == psq_pkg::CHORD_MAX - 1);
      send_item(psq_pkg::CMD_WR_VEL, '0, '0, psq_pkg::VALUE_W'(16383), 1'b0);
      send_item(psq_pkg::CMD_WR_VEL, 6'd63, '1, psq_pkg::VALUE_W'(-5), 1'b1);
      send_item(psq_pkg::CMD_WR_PAT, 6'd63, '0, '0, 1'b0);
      send_item(psq_pkg::CMD_WR_PAT, '0, '0, psq_pkg::VALUE_W'(16383), 1'b0);
      send_item(psq_pkg::CMD_WR_PAT, 6'd1, '0, psq_pkg::VALUE_W'(-16384), 1'b0);
      wait_drained();
      set_lengths(7'd2, 7'd1, 7'd1);

      // longest note, then overrun by shrinking the step under way
      send_tick();
      send_item(psq_pkg::CMD_WR_PAT, '0, '0, psq_pkg::VALUE_W'(1), 1'b0);
      send_tick();
      // longest rest
      send_tick();
      // zero length plays as a quarter note
      send_item(psq_pkg::CMD_RESTART, '0, '0, '0, 1'b0);
      send_item(psq_pkg::CMD_WR_PAT, '0, '0, '0, 1'b0);
      send_tick();

      // receiver holds off while one-tick chords keep coming
      wait_drained();
      set_lengths(7'd1, 7'd1, 7'd1);
      send_item(psq_pkg::CMD_WR_PAT, '0, '0, psq_pkg::VALUE_W'(1), 1'b0);
      hold_off_req = 1'b1;
      for (k = 0; k < 24; k++) send_tick();

      // random phases over several table lengths and idling mixes
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         case (ph / 2)
            0: begin
               tx_idle_pct = 27;
               rx_idle_pct = 62;
            end
            1: begin
               tx_idle_pct = 62;
               rx_idle_pct = 27;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         set_lengths(phase_len[ph][0], phase_len[ph][1], phase_len[ph][2]);
         run_random_phase(PHASE_ITEMS, ph == 1);
      end

      wait_drained();
      if (sb.error_count == 0 && sb.due_notes.size() == 0)
         $display("tb_pattern_step_sequencer: done, clean");
      else
         $display("tb_pattern_step_sequencer: done, errors");
      $finish;
   end

endmodule
